### design/sawc_pkg.sv
// Shared types and constants of the set-associative write-back cache.
// Depends on nothing; every other design file imports it.
package sawc_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 32;

    localparam int DEF_WAYS        = 4;
    localparam int DEF_SETS        = 16;
    localparam int DEF_BLOCK_BYTES = 16;
    localparam int DEF_MEM_BYTES   = 65536;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [DATA_W-1:0] byte_t;

endpackage

### design/sawc_line_ram.sv
// Line data storage of the cache: one write port, one registered read port.
// Depends on sawc_pkg.
module sawc_line_ram #(
    parameter int DEPTH = sawc_pkg::DEF_WAYS * sawc_pkg::DEF_SETS * sawc_pkg::DEF_BLOCK_BYTES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [sawc_pkg::DATA_W-1:0] wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [sawc_pkg::DATA_W-1:0] rdata
);
    import sawc_pkg::*;

    byte_t mem_reg [DEPTH];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sawc_main_mem.sv
// Main memory behind the cache, with a zeroing sweep after reset.
// Depends on sawc_pkg.
module sawc_main_mem #(
    parameter int MEM_BYTES = sawc_pkg::DEF_MEM_BYTES,
    parameter int AW        = $clog2(MEM_BYTES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [sawc_pkg::DATA_W-1:0] wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [sawc_pkg::DATA_W-1:0] rdata,
    output logic                   busy
);
    import sawc_pkg::*;

    byte_t          mem_reg [MEM_BYTES];
    byte_t          rdata_reg;
    logic [AW-1:0]  clr_idx_reg;
    logic           clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(MEM_BYTES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem_reg[clr_idx_reg] <= '0;
        end
        else if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

### design/set_assoc_writeback_cache.sv
// Top level: lookup sequencer, tag and stamp rows, valid and dirty flags.
// Depends on sawc_pkg, sawc_line_ram and sawc_main_mem.
//
//   channel   signals                                  direction
//   request   in_valid/in_ready, op, address, write_data     in
//   result    out_valid/out_ready, read_data, hit,           out
//             hit_count, miss_count
//
// A hit goes through the lookup and done steps from accept to result. A miss
// adds a victim search over the ways, a write-back of the block for a dirty
// victim, a direct write to main memory for a write miss and a fill of the
// block, all through the byte-wide ports of main memory and of the line RAM.
// After reset the main memory is zeroed byte by byte; no beat is accepted
// in that time. A stalled result holds the sequencer in its last step.
module set_assoc_writeback_cache #(
    parameter int WAYS        = sawc_pkg::DEF_WAYS,
    parameter int SETS        = sawc_pkg::DEF_SETS,
    parameter int BLOCK_BYTES = sawc_pkg::DEF_BLOCK_BYTES,
    parameter int MEM_BYTES   = sawc_pkg::DEF_MEM_BYTES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [sawc_pkg::ADDR_W-1:0]  address,
    input  logic [sawc_pkg::DATA_W-1:0]  write_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sawc_pkg::DATA_W-1:0]  read_data,
    output logic                         hit,
    output logic [sawc_pkg::COUNT_W-1:0] hit_count,
    output logic [sawc_pkg::COUNT_W-1:0] miss_count
);
    import sawc_pkg::*;

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int OFF_W    = (OFF_BITS > 0) ? OFF_BITS : 1;
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_RAW  = ADDR_W - OFF_BITS - SET_BITS;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SCAN_W   = $clog2(WAYS + 1);
    localparam int LINES    = SETS * WAYS;
    localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LD_DEPTH = LINES * BLOCK_BYTES;
    localparam int LD_AW    = (LD_DEPTH > 1) ? $clog2(LD_DEPTH) : 1;
    localparam int CNT_W    = $clog2(BLOCK_BYTES + 1);
    localparam int MEM_AW   = $clog2(MEM_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_VICT = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_MW   = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic logic [OFF_W-1:0] off_of(input logic [ADDR_W-1:0] a);
        return OFF_W'(a & ADDR_W'(BLOCK_BYTES - 1));
    endfunction

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a);
        return SET_W'((a >> OFF_BITS) & ADDR_W'(SETS - 1));
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
        return TAG_W'(a >> (OFF_BITS + SET_BITS));
    endfunction

    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        return LINE_W'(int'(s) * WAYS + int'(w));
    endfunction

    function automatic logic [LD_AW-1:0] ld_addr(input logic [LINE_W-1:0] l,
                                                 input logic [OFF_W-1:0] i);
        return LD_AW'(int'(l) * BLOCK_BYTES + int'(i));
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic [ADDR_W-1:0] a);
        logic [23:0] wide;
        wide = {8'h00, a};
        return wide[MEM_AW-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] blk_addr(input logic [TAG_W-1:0] t,
                                                   input logic [SET_W-1:0] s,
                                                   input logic [OFF_W-1:0] i);
        return (ADDR_W'(t) << (OFF_BITS + SET_BITS)) | (ADDR_W'(s) << OFF_BITS)
               | ADDR_W'(i);
    endfunction

    logic [2:0]              state_reg;
    logic                    op_reg;
    logic [ADDR_W-1:0]       addr_reg;
    byte_t                   wdata_reg;
    logic [STAMP_W-1:0]      acnt_reg;
    logic [COUNT_W-1:0]      hit_tot_reg;
    logic [COUNT_W-1:0]      miss_tot_reg;
    logic                    hit_flag_reg;
    logic [WAY_W-1:0]        way_reg;
    logic [SCAN_W-1:0]       scan_reg;
    logic [CNT_W-1:0]        cnt_reg;
    byte_t                   rbyte_reg;
    logic                    valid_reg [LINES];
    logic                    dirty_reg [LINES];
    logic                    out_valid_reg;
    byte_t                   out_data_reg;
    logic                    out_hit_reg;
    logic [COUNT_W-1:0]      out_hits_reg;
    logic [COUNT_W-1:0]      out_miss_reg;

    logic [WAYS*TAG_W-1:0]   tag_mem_reg   [SETS];
    logic [WAYS*STAMP_W-1:0] stamp_mem_reg [SETS];
    logic [WAYS*TAG_W-1:0]   tag_row_reg;
    logic [WAYS*STAMP_W-1:0] stamp_row_reg;

    logic [OFF_W-1:0]        cur_off;
    logic [SET_W-1:0]        cur_set;
    logic [TAG_W-1:0]        cur_tag;
    logic [LINE_W-1:0]       vic_line;
    logic [TAG_W-1:0]        vic_tag;
    logic [OFF_W-1:0]        idx;
    logic [OFF_W-1:0]        prev_idx;
    logic                    found;
    logic [WAY_W-1:0]        hit_way;
    logic [STAMP_W-1:0]      scan_stamp;
    logic [STAMP_W-1:0]      best_stamp;
    logic                    row_re;
    logic                    row_we;
    logic                    accept;
    logic                    finish;
    logic [WAYS*TAG_W-1:0]   tag_row_new;
    logic [WAYS*STAMP_W-1:0] stamp_row_new;

    logic                    ld_we;
    logic [LD_AW-1:0]        ld_waddr;
    byte_t                   ld_wdata;
    logic                    ld_re;
    logic [LD_AW-1:0]        ld_raddr;
    byte_t                   ld_rdata;

    logic                    mm_we;
    logic [MEM_AW-1:0]       mm_waddr;
    byte_t                   mm_wdata;
    logic                    mm_re;
    logic [MEM_AW-1:0]       mm_raddr;
    byte_t                   mm_rdata;
    logic                    mm_busy;

    sawc_line_ram #(
        .DEPTH (LD_DEPTH),
        .AW    (LD_AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ld_we),
        .waddr (ld_waddr),
        .wdata (ld_wdata),
        .re    (ld_re),
        .raddr (ld_raddr),
        .rdata (ld_rdata)
    );

    sawc_main_mem #(
        .MEM_BYTES (MEM_BYTES),
        .AW        (MEM_AW)
    ) u_main_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mm_we),
        .waddr (mm_waddr),
        .wdata (mm_wdata),
        .re    (mm_re),
        .raddr (mm_raddr),
        .rdata (mm_rdata),
        .busy  (mm_busy)
    );

    assign cur_off  = off_of(addr_reg);
    assign cur_set  = set_of(addr_reg);
    assign cur_tag  = tag_of(addr_reg);
    assign vic_line = line_of(cur_set, way_reg);
    assign vic_tag  = tag_row_reg[way_reg*TAG_W +: TAG_W];
    assign idx      = cnt_reg[OFF_W-1:0];
    assign prev_idx = OFF_W'(cnt_reg - 1'b1);

    assign in_ready = (state_reg == S_IDLE) && !mm_busy;
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign row_re   = accept;
    assign row_we   = finish;

    always_comb
    begin
        found   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && valid_reg[line_of(cur_set, WAY_W'(w))]
                && (tag_row_reg[w*TAG_W +: TAG_W] == cur_tag))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        scan_stamp = '0;
        best_stamp = '0;
        if (scan_reg < SCAN_W'(WAYS))
        begin
            if (valid_reg[line_of(cur_set, WAY_W'(scan_reg))])
            begin
                scan_stamp = stamp_row_reg[WAY_W'(scan_reg)*STAMP_W +: STAMP_W];
            end
        end
        if (valid_reg[vic_line])
        begin
            best_stamp = stamp_row_reg[way_reg*STAMP_W +: STAMP_W];
        end
    end

    always_comb
    begin
        tag_row_new   = tag_row_reg;
        stamp_row_new = stamp_row_reg;
        if (!hit_flag_reg)
        begin
            tag_row_new[way_reg*TAG_W +: TAG_W] = cur_tag;
        end
        stamp_row_new[way_reg*STAMP_W +: STAMP_W] = acnt_reg;
    end

    always_comb
    begin
        ld_we    = 1'b0;
        ld_waddr = ld_addr(vic_line, cur_off);
        ld_wdata = wdata_reg;
        ld_re    = 1'b0;
        ld_raddr = ld_addr(line_of(cur_set, hit_way), cur_off);
        mm_we    = 1'b0;
        mm_waddr = mem_addr(addr_reg);
        mm_wdata = wdata_reg;
        mm_re    = 1'b0;
        mm_raddr = mem_addr(blk_addr(cur_tag, cur_set, idx));
        unique case (state_reg)
            S_LOOK:
            begin
                ld_re = found && (op_reg == OP_READ);
            end
            S_WB:
            begin
                ld_raddr = ld_addr(vic_line, idx);
                ld_re    = cnt_reg < CNT_W'(BLOCK_BYTES);
                mm_we    = cnt_reg != '0;
                mm_waddr = mem_addr(blk_addr(vic_tag, cur_set, prev_idx));
                mm_wdata = ld_rdata;
            end
            S_MW:
            begin
                mm_we = 1'b1;
            end
            S_FILL:
            begin
                mm_re    = cnt_reg < CNT_W'(BLOCK_BYTES);
                ld_we    = cnt_reg != '0;
                ld_waddr = ld_addr(vic_line, prev_idx);
                ld_wdata = mm_rdata;
            end
            S_DONE:
            begin
                ld_we = finish && hit_flag_reg && (op_reg == OP_WRITE);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_re)
        begin
            tag_row_reg   <= tag_mem_reg[set_of(address)];
            stamp_row_reg <= stamp_mem_reg[set_of(address)];
        end
        if (row_we)
        begin
            tag_mem_reg[cur_set]   <= tag_row_new;
            stamp_mem_reg[cur_set] <= stamp_row_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (state_reg == S_FILL && cnt_reg != '0 && prev_idx == cur_off)
        begin
            rbyte_reg <= mm_rdata;
        end
        if (finish)
        begin
            out_hit_reg  <= hit_flag_reg;
            out_hits_reg <= hit_flag_reg ? hit_tot_reg + 1'b1 : hit_tot_reg;
            out_miss_reg <= hit_flag_reg ? miss_tot_reg : miss_tot_reg + 1'b1;
            if (op_reg == OP_WRITE)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg <= hit_flag_reg ? ld_rdata : rbyte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acnt_reg      <= '0;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            hit_flag_reg  <= 1'b0;
            way_reg       <= '0;
            scan_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < LINES; l++)
            begin
                valid_reg[l] <= 1'b0;
                dirty_reg[l] <= 1'b0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        acnt_reg  <= acnt_reg + 1'b1;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    hit_flag_reg <= found;
                    scan_reg     <= SCAN_W'(1);
                    way_reg      <= found ? hit_way : '0;
                    state_reg    <= found ? S_DONE : S_VICT;
                end
                S_VICT:
                begin
                    cnt_reg <= '0;
                    if (scan_reg >= SCAN_W'(WAYS))
                    begin
                        if (valid_reg[vic_line] && dirty_reg[vic_line])
                        begin
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            state_reg <= (op_reg == OP_WRITE) ? S_MW : S_FILL;
                        end
                    end
                    else
                    begin
                        if (scan_stamp < best_stamp)
                        begin
                            way_reg <= WAY_W'(scan_reg);
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_WB:
                begin
                    if (cnt_reg == CNT_W'(BLOCK_BYTES))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (op_reg == OP_WRITE) ? S_MW : S_FILL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MW:
                begin
                    state_reg <= S_FILL;
                end
                S_FILL:
                begin
                    if (cnt_reg == CNT_W'(BLOCK_BYTES))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (hit_flag_reg)
                        begin
                            hit_tot_reg <= hit_tot_reg + 1'b1;
                            if (op_reg == OP_WRITE)
                            begin
                                dirty_reg[vic_line] <= 1'b1;
                            end
                        end
                        else
                        begin
                            miss_tot_reg        <= miss_tot_reg + 1'b1;
                            valid_reg[vic_line] <= 1'b1;
                            dirty_reg[vic_line] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_data_reg;
    assign hit        = out_hit_reg;
    assign hit_count  = out_hits_reg;
    assign miss_count = out_miss_reg;

endmodule

### design/sawc_checker.sv
// Port-level checks of the cache and the bind that attaches them.
// Depends on sawc_pkg and set_assoc_writeback_cache.
module sawc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sawc_pkg::DATA_W-1:0]  read_data,
    input logic                         hit,
    input logic [sawc_pkg::COUNT_W-1:0] hit_count,
    input logic [sawc_pkg::COUNT_W-1:0] miss_count
);
    import sawc_pkg::*;

    logic [COUNT_W-1:0] beats_reg;
    logic [1:0]         pend_reg;
    logic               in_beat;
    logic               out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            if (out_beat)
            begin
                beats_reg <= beats_reg + 1'b1;
            end
            pend_reg <= pend_reg + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(hit)
            && $stable(hit_count) && $stable(miss_count))
        else $error("result beat changed while stalled");

    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> COUNT_W'(hit_count + miss_count) == COUNT_W'(beats_reg + 1'b1))
        else $error("hit and miss counts do not add up to the result beats");

    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests outstanding");

endmodule

bind set_assoc_writeback_cache sawc_checker u_sawc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .hit        (hit),
    .hit_count  (hit_count),
    .miss_count (miss_count)
);

### verif/set_assoc_writeback_cache_tb.sv
// Testbench of the set-associative write-back cache: directed and random byte
// accesses checked against a behavioral cache model. Depends on sawc_pkg and the RTL.
module set_assoc_writeback_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sawc_pkg::*;

    localparam int WAYS  = DEF_WAYS;
    localparam int SETS  = DEF_SETS;
    localparam int BB    = DEF_BLOCK_BYTES;
    localparam int MEMB  = DEF_MEM_BYTES;
    localparam int LINES = WAYS * SETS;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        byte_t             rdata;
        logic              hit;
        logic [31:0]       hits;
        logic [31:0]       misses;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = OP_READ;
    logic [ADDR_W-1:0] address = '0;
    byte_t write_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    byte_t read_data;
    logic hit;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;

    set_assoc_writeback_cache u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .address(address), .write_data(write_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_data(read_data), .hit(hit),
        .hit_count(hit_count), .miss_count(miss_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Model state of the cache.
    logic [7:0]  m_tag   [LINES];
    logic        m_valid [LINES];
    logic        m_dirty [LINES];
    logic [31:0] m_stamp [LINES];
    byte_t       m_line  [LINES*BB];
    byte_t       m_mem   [MEMB];
    logic [31:0] m_accesses, m_hits, m_misses;

    access_result_t expected_results[$];
    int errors = 0;
    int checked = 0;
    int hit_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    function automatic access_result_t predict_access(logic wr, logic [15:0] a, byte_t wd);
        access_result_t r;
        int off, set, tag, line, base, victim;
        bit found;
        off = a % BB;
        set = (a / BB) % SETS;
        tag = a / (BB * SETS);
        found = 0;
        line = 0;
        r = '0;
        m_accesses++;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && m_valid[set*WAYS+w] && m_tag[set*WAYS+w] == tag)
            begin
                found = 1;
                line = set*WAYS + w;
            end
        end
        if (found)
        begin
            m_hits++;
            m_stamp[line] = m_accesses;
            if (wr)
            begin
                m_line[line*BB+off] = wd;
                m_dirty[line] = 1;
            end
            else
                r.rdata = m_line[line*BB+off];
        end
        else
        begin
            m_misses++;
            if (wr)
                m_mem[a] = wd;
            victim = 0;
            for (int w = 1; w < WAYS; w++)
                if (m_stamp[set*WAYS+w] < m_stamp[set*WAYS+victim])
                    victim = w;
            line = set*WAYS + victim;
            if (m_valid[line] && m_dirty[line])
            begin
                base = (m_tag[line] * SETS + set) * BB;
                for (int i = 0; i < BB; i++)
                    m_mem[(base+i) % MEMB] = m_line[line*BB+i];
            end
            m_tag[line] = tag;
            m_valid[line] = 1;
            m_dirty[line] = 0;
            m_stamp[line] = m_accesses;
            base = (tag * SETS + set) * BB;
            for (int i = 0; i < BB; i++)
                m_line[line*BB+i] = m_mem[(base+i) % MEMB];
            if (!wr)
                r.rdata = m_line[line*BB+off];
        end
        r.hit = found;
        r.hits = m_hits;
        r.misses = m_misses;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h, expected %0h", checked, what, got, want);
        errors++;
    endtask

    task automatic send_access(logic wr, logic [15:0] a, byte_t wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= wr;
        address <= a;
        write_data <= wd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_access(wr, a, wd));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Checks each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        access_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected beat", 32'd1, 32'd0);
            end
            else
            begin
                e = expected_results.pop_front();
                if (read_data !== e.rdata) report_mismatch("read_data", read_data, e.rdata);
                if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
                if (hit_count !== e.hits) report_mismatch("hit_count", hit_count, e.hits);
                if (miss_count !== e.misses) report_mismatch("miss_count", miss_count, e.misses);
                if (e.hit) hit_seen++;
            end
            checked++;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Counts cycles with work pending but no accepted beat; reset-time clearing is included.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && expected_results.size() == 0)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("set_assoc_writeback_cache_tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_WRITE, 16'h0003, 8'hFF);
        send_access(OP_READ, 16'h0003, 8'h00);
        send_access(OP_WRITE, 16'hFFFF, 8'hA5);
        send_access(OP_READ, 16'hFFFF, 8'h5A);
        send_access(OP_WRITE, 16'h0000, 8'h01);
        // Five tags in set 0 force a dirty eviction and refetch.
        for (int t = 1; t <= 5; t++)
            send_access(OP_READ, 16'(t * BB * SETS), 8'h00);
        send_access(OP_READ, 16'h0003, 8'h00);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_WRITE, 16'h7FF0, 8'h80);
        send_access(OP_WRITE, 16'h8000, 8'h7F);
        send_access(OP_READ, 16'h7FF0, 8'h00);
        send_access(OP_READ, 16'h8000, 8'h00);
        wait_drained();
    endtask

    task automatic test_random(int n, int idle, int stall);
        logic [15:0] a;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            // Mostly a small footprint so sets conflict and lines hit again.
            if ($urandom_range(9) < 7)
                a = 16'($urandom_range(7) << 8) | 16'($urandom_range(255));
            else
                a = 16'($urandom);
            send_access(1'($urandom), a, 8'($urandom));
        end
        wait_drained();
    endtask

    initial
    begin
        m_accesses = 0;
        m_hits = 0;
        m_misses = 0;
        for (int i = 0; i < LINES; i++)
        begin
            m_tag[i] = '0; m_valid[i] = 0; m_dirty[i] = 0; m_stamp[i] = '0;
        end
        for (int i = 0; i < LINES*BB; i++) m_line[i] = '0;
        for (int i = 0; i < MEMB; i++) m_mem[i] = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(360, 0, 0);
        test_random(360, 80, 0);
        test_random(360, 0, 80);
        test_random(360, 33, 33);
        $display("Covered %0d accesses (%0d hits) with reads, writes, dirty evictions and",
                 checked, hit_seen);
        $display("address extremes under sender gaps and receiver stalls.");
        if (errors == 0)
            $display("set_assoc_writeback_cache_tb: done, clean");
        else
            $display("set_assoc_writeback_cache_tb: done, errors");
        $finish;
    end
endmodule

### files.f
design/sawc_pkg.sv
design/sawc_line_ram.sv
design/sawc_main_mem.sv
design/set_assoc_writeback_cache.sv
design/sawc_checker.sv
verif/set_assoc_writeback_cache_tb.sv
